>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, command and status codes, and the cell command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int TOTAL_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain in the cycle of a transfer.
  typedef struct packed {
    logic                       go;
    opcode_t                    op;
    logic signed [VALUE_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry and decides its next content from its two neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic                      clk,
  input  wire cell_cmd_t                 cmd,
  input  wire logic                      occupied,
  input  wire logic                      left_place,
  input  wire logic signed [VALUE_W-1:0] left_value,
  input  wire logic signed [VALUE_W-1:0] right_value,
  output logic                           place,
  output logic signed [VALUE_W-1:0]      value
);

  logic signed [VALUE_W-1:0] entry;
  logic signed [VALUE_W-1:0] entry_next;

  // The new value belongs at or before this cell when the cell is free or
  // holds a strictly larger entry; equal entries stay ahead of the new one.
  assign place = !occupied || (entry > cmd.value);
  assign value = entry;

  always_comb begin
    entry_next = entry;
    if (cmd.go) begin
      if (cmd.op == OP_REMOVE) begin
        entry_next = right_value;
      end else if (left_place) begin
        entry_next = left_value;
      end else if (place) begin
        entry_next = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded min-priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Result: the result strobe rises in the cycle after the command transfer.
// Throughput: one command per cycle; busy stays low, since every cell of the
// chain that moves shifts or loads in the same cycle as the transfer.
// Reset: rst clears the entry count and the result strobe; cell contents are
// left as they are and are only read below the entry count.
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      opcode,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           done,
  output logic [1:0]                     status,
  output logic signed [VALUE_W-1:0]      removed_value,
  output logic [TOTAL_W-1:0]             entry_total
);

  logic [COUNT_W-1:0]        count;
  logic [COUNT_W-1:0]        count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      legal;
  status_t                   status_next;
  logic signed [VALUE_W-1:0] removed_next;
  cell_cmd_t                 cmd;

  logic [CAPACITY-1:0]       occupied;
  logic [CAPACITY-1:0]       place;
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == COUNT_W'(CAPACITY));
  assign empty  = (count == '0);

  always_comb begin
    legal        = 1'b0;
    status_next  = STATUS_DONE;
    removed_next = '0;
    count_next   = count;
    if (opcode == OP_INSERT) begin
      if (full) begin
        status_next = STATUS_FULL;
      end else begin
        legal      = 1'b1;
        count_next = count + COUNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        legal        = 1'b1;
        removed_next = cell_value[0];
        count_next   = count - COUNT_W'(1);
      end
    end
  end

  assign cmd.go    = accept && legal;
  assign cmd.op    = opcode_t'(opcode);
  assign cmd.value = value;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                      left_place;
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;

    assign occupied[k] = (COUNT_W'(k) < count);

    if (k == 0) begin : g_first
      assign left_place = 1'b0;
      assign left_value = value;
    end else begin : g_inner
      assign left_place = place[k-1];
      assign left_value = cell_value[k-1];
    end

    // The last cell has no right neighbour; after a remove its content lies
    // beyond the count and is never read.
    if (k == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[k];
    end else begin : g_body
      assign right_value = cell_value[k+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occupied[k]),
      .left_place  (left_place),
      .left_value  (left_value),
      .right_value (right_value),
      .place       (place[k]),
      .value       (cell_value[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      removed_value <= removed_next;
      entry_total   <= TOTAL_W'(count_next);
    end
  end

endmodule

`default_nettype wire
